// File: hw/rtl/natv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// natv_pkg: shared types and constants of the address text validator
// Character classes, checker modes, result and error codes, checker state.
// ----------------------------------------------------------------------------
package natv_pkg;

    // result kinds
    localparam logic [2:0] KIND_UNKNOWN = 3'd0;
    localparam logic [2:0] KIND_IPV4    = 3'd1;
    localparam logic [2:0] KIND_IPV6    = 3'd2;
    localparam logic [2:0] KIND_MAC     = 3'd3;
    localparam logic [2:0] KIND_INVALID = 3'd4;

    // error codes
    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_NON_DIGIT = 4'd1;
    localparam logic [3:0] ERR_LEAD_ZERO = 4'd2;
    localparam logic [3:0] ERR_OVER_255  = 4'd3;
    localparam logic [3:0] ERR_GRP_COUNT = 4'd4;
    localparam logic [3:0] ERR_EMPTY     = 4'd5;
    localparam logic [3:0] ERR_TOO_LONG  = 4'd6;
    localparam logic [3:0] ERR_NON_HEX   = 4'd7;
    localparam logic [3:0] ERR_MAC_LEN   = 4'd8;

    // checker modes
    typedef logic [1:0] chk_mode_t;
    localparam chk_mode_t CHK_DOT        = 2'd0;
    localparam chk_mode_t CHK_HEX        = 2'd1;
    localparam chk_mode_t CHK_COLON_PAIR = 2'd2;
    localparam chk_mode_t CHK_DASH_PAIR  = 2'd3;

    // group counts required by each format
    localparam logic [3:0] NEED_DOT  = 4'd4;
    localparam logic [3:0] NEED_HEX  = 4'd8;
    localparam logic [3:0] NEED_PAIR = 4'd6;

    localparam logic [2:0] HEX_MAX_LEN  = 3'd4;
    localparam logic [2:0] PAIR_LEN     = 3'd2;
    localparam logic [2:0] LEN_SAT      = 3'd7;
    localparam logic [3:0] SEPS_SAT     = 4'd15;
    localparam logic [8:0] VAL_SAT      = 9'd256;
    localparam logic [8:0] OCTET_MAX    = 9'd255;

    // characters
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one classified character beat
    typedef struct packed {
        logic       is_last;
        logic       is_dot;
        logic       is_colon;
        logic       is_dash;
        logic       is_dec;
        logic       is_hex;
        logic       is_zero;
        logic [3:0] digit;
    } char_class_t;

    typedef struct packed {
        logic [3:0] seps;
        logic [2:0] len;
        logic [8:0] val;
        logic       bad;
        logic       lead0;
        logic [3:0] err;
        logic [3:0] grp;
    } chk_state_t;

    typedef struct packed {
        logic [3:0] err;
        logic [3:0] grp;
    } chk_result_t;

    function automatic logic [3:0] group_index(logic [3:0] seps);
        return (seps >= 4'd14) ? 4'd15 : seps + 4'd1;
    endfunction

    function automatic chk_state_t close_group(chk_state_t s, chk_mode_t mode);
        chk_state_t r;
        logic [3:0] e;
        r = s;
        e = ERR_NONE;
        if (s.err == ERR_NONE)
        begin
            priority if (s.len == 3'd0)
                e = ERR_EMPTY;
            else if (mode == CHK_DOT)
            begin
                priority if (s.bad)
                    e = ERR_NON_DIGIT;
                else if (s.len > 3'd1 && s.lead0)
                    e = ERR_LEAD_ZERO;
                else if (s.val > OCTET_MAX)
                    e = ERR_OVER_255;
                else
                    e = ERR_NONE;
            end
            else if (mode == CHK_HEX)
            begin
                priority if (s.len > HEX_MAX_LEN)
                    e = ERR_TOO_LONG;
                else if (s.bad)
                    e = ERR_NON_HEX;
                else
                    e = ERR_NONE;
            end
            else
            begin
                priority if (s.len != PAIR_LEN)
                    e = ERR_MAC_LEN;
                else if (s.bad)
                    e = ERR_NON_HEX;
                else
                    e = ERR_NONE;
            end
            if (e != ERR_NONE)
            begin
                r.err = e;
                r.grp = group_index(s.seps);
            end
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/natv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// natv_front: input stage of the address text validator
// Accepts character beats and classifies each one into the queue.
// ----------------------------------------------------------------------------
module natv_front
    import natv_pkg::*;
(
    input  logic        addr_valid,
    output logic        addr_stall,
    input  logic [7:0]  addr_char,
    input  logic        is_last,
    input  logic        queue_full,
    output logic        push,
    output char_class_t push_data
);

    logic is_dec;
    logic is_alpha_hex;

    assign addr_stall = queue_full;
    assign push       = addr_valid && !queue_full;

    assign is_dec       = (addr_char >= CH_ZERO) && (addr_char <= CH_NINE);
    assign is_alpha_hex = ((addr_char >= CH_LO_A) && (addr_char <= CH_LO_F)) ||
                          ((addr_char >= CH_UP_A) && (addr_char <= CH_UP_F));

    always_comb
    begin
        push_data.is_last  = is_last;
        push_data.is_dot   = (addr_char == CH_DOT);
        push_data.is_colon = (addr_char == CH_COLON);
        push_data.is_dash  = (addr_char == CH_DASH);
        push_data.is_dec   = is_dec;
        push_data.is_hex   = is_dec || is_alpha_hex;
        push_data.is_zero  = (addr_char == CH_ZERO);
        push_data.digit    = addr_char[3:0];
    end

endmodule

// File: hw/rtl/natv_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// natv_queue: short queue of classified beats
// Decouples the front stall from the back stall.
// ----------------------------------------------------------------------------
module natv_queue
    import natv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  char_class_t push_data,
    input  logic        pop,
    output char_class_t pop_data,
    output logic        not_empty,
    output logic        full
);

    char_class_t           mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;

    assign pop_data  = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + QUEUE_AW'(1);
        if (pop)
            rd_ptr_next = rd_ptr_reg + QUEUE_AW'(1);
        unique case ({push, pop})
            2'b10:   count_next = count_reg + (QUEUE_AW+1)'(1);
            2'b01:   count_next = count_reg - (QUEUE_AW+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: hw/rtl/natv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// natv_checker: one group-format checker
// Tracks group count, length, value and first error for one format.
// ----------------------------------------------------------------------------
module natv_checker
    import natv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  chk_mode_t   mode,
    input  logic        beat,
    input  char_class_t cls,
    output chk_result_t result
);

    chk_state_t state_reg, state_next;
    chk_state_t fed;
    chk_state_t fin;
    logic       is_delim;
    logic [3:0] need;
    logic [11:0] prod;

    always_comb
    begin
        unique case (mode)
            CHK_DOT:
            begin
                is_delim = cls.is_dot;
                need     = NEED_DOT;
            end
            CHK_HEX:
            begin
                is_delim = cls.is_colon;
                need     = NEED_HEX;
            end
            CHK_COLON_PAIR:
            begin
                is_delim = cls.is_colon;
                need     = NEED_PAIR;
            end
            default:
            begin
                is_delim = cls.is_dash;
                need     = NEED_PAIR;
            end
        endcase
    end

    // value times ten plus the new digit
    assign prod = {state_reg.val, 3'b000} + {2'b00, state_reg.val, 1'b0} +
                  {8'd0, cls.digit};

    always_comb
    begin
        fed = state_reg;
        if (is_delim)
        begin
            fed = close_group(state_reg, mode);
            if (state_reg.seps != SEPS_SAT)
                fed.seps = state_reg.seps + 4'd1;
            fed.len   = '0;
            fed.val   = '0;
            fed.bad   = 1'b0;
            fed.lead0 = 1'b0;
        end
        else
        begin
            if (state_reg.len == 3'd0 && cls.is_zero)
                fed.lead0 = 1'b1;
            if (state_reg.len != LEN_SAT)
                fed.len = state_reg.len + 3'd1;
            if (mode == CHK_DOT)
            begin
                if (!cls.is_dec)
                    fed.bad = 1'b1;
                else
                    fed.val = (prod > 12'(VAL_SAT)) ? VAL_SAT : prod[8:0];
            end
            else if (!cls.is_hex)
                fed.bad = 1'b1;
        end
    end

    // close the final group, then check the group count
    always_comb
    begin
        fin = close_group(fed, mode);
        if (fin.err == ERR_NONE && group_index(fin.seps) != need)
        begin
            fin.err = ERR_GRP_COUNT;
            fin.grp = '0;
        end
        result.err = fin.err;
        result.grp = fin.grp;
    end

    always_comb
    begin
        state_next = state_reg;
        if (beat)
            state_next = cls.is_last ? '0 : fed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else
            state_reg <= state_next;
    end

endmodule

// File: hw/rtl/natv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// natv_back: checking stage of the address text validator
// Runs the four checkers, picks the verdict and holds it for the receiver.
// ----------------------------------------------------------------------------
module natv_back
    import natv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_not_empty,
    input  char_class_t q_data,
    output logic        q_pop,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  addr_kind,
    output logic [3:0]  error_code,
    output logic [3:0]  error_group
);

    logic [2:0]  seen_reg, seen_next;
    logic        valid_reg, valid_next;
    logic [2:0]  kind_reg, kind_next;
    logic [3:0]  code_reg, code_next;
    logic [3:0]  grp_reg, grp_next;
    logic        out_free;
    logic [2:0]  seen_now;
    chk_result_t dot_res, hex_res, colon_res, dash_res;
    chk_result_t pick;
    logic        have_pick;
    logic [2:0]  good;

    assign out_free = !valid_reg || !result_stall;
    // hold a last beat until the result register can take it
    assign q_pop    = q_not_empty && (!q_data.is_last || out_free);

    natv_checker u_dot (
        .clk(clk), .rst_n(rst_n), .mode(CHK_DOT),
        .beat(q_pop), .cls(q_data), .result(dot_res)
    );
    natv_checker u_hex (
        .clk(clk), .rst_n(rst_n), .mode(CHK_HEX),
        .beat(q_pop), .cls(q_data), .result(hex_res)
    );
    natv_checker u_colon (
        .clk(clk), .rst_n(rst_n), .mode(CHK_COLON_PAIR),
        .beat(q_pop), .cls(q_data), .result(colon_res)
    );
    natv_checker u_dash (
        .clk(clk), .rst_n(rst_n), .mode(CHK_DASH_PAIR),
        .beat(q_pop), .cls(q_data), .result(dash_res)
    );

    assign seen_now = seen_reg | {q_data.is_dash, q_data.is_colon, q_data.is_dot};

    always_comb
    begin
        have_pick = 1'b1;
        pick      = dot_res;
        good      = KIND_IPV4;
        priority if (seen_now[0])
        begin
            pick = dot_res;
            good = KIND_IPV4;
        end
        else if (seen_now[1])
        begin
            if (hex_res.err == ERR_NONE)
            begin
                pick = hex_res;
                good = KIND_IPV6;
            end
            else
            begin
                pick = seen_now[2] ? dash_res : colon_res;
                good = KIND_MAC;
            end
        end
        else if (seen_now[2])
        begin
            pick = dash_res;
            good = KIND_MAC;
        end
        else
            have_pick = 1'b0;
    end

    always_comb
    begin
        seen_next  = seen_reg;
        valid_next = valid_reg;
        kind_next  = kind_reg;
        code_next  = code_reg;
        grp_next   = grp_reg;
        if (!result_stall)
            valid_next = 1'b0;
        if (q_pop)
        begin
            seen_next = q_data.is_last ? 3'd0 : seen_now;
            if (q_data.is_last)
            begin
                valid_next = 1'b1;
                kind_next  = KIND_UNKNOWN;
                code_next  = ERR_NONE;
                grp_next   = '0;
                if (have_pick)
                begin
                    if (pick.err == ERR_NONE)
                        kind_next = good;
                    else
                    begin
                        kind_next = KIND_INVALID;
                        code_next = pick.err;
                        grp_next  = pick.grp;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg  <= seen_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        code_reg <= code_next;
        grp_reg  <= grp_next;
    end

    assign result_valid = valid_reg;
    assign addr_kind    = kind_reg;
    assign error_code   = code_reg;
    assign error_group  = grp_reg;

endmodule

// File: hw/rtl/network_address_text_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// network_address_text_validator: classifies an address string
// Sorts a character stream into IPv4, IPv6, MAC, unknown or invalid.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one character per beat on addr_char, with is_last high on
//   the final character. A beat is taken when addr_valid is high and
//   addr_stall is low. Strings follow each other with no gap.
//   Output channel: one result beat per string (addr_kind, error_code,
//   error_group), taken when result_valid is high and result_stall is low.
//   Throughput: one character per cycle while addr_stall is low, set by the
//   four group checkers that update once per beat.
//   The last character is written into the queue when taken; once it is at
//   the queue head and the result register is free, the back pops it and
//   loads the result register.
//   When the receiver stalls, the result holds; the back keeps consuming
//   characters of the next string until its last character reaches the
//   queue head, then the four-entry queue fills and addr_stall rises.
//   Reset clears the queue, all checker state and result_valid; the block
//   is ready for a new string right after reset.
// ----------------------------------------------------------------------------
module network_address_text_validator
    import natv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       addr_valid,
    output logic       addr_stall,
    input  logic [7:0] addr_char,
    input  logic       is_last,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [2:0] addr_kind,
    output logic [3:0] error_code,
    output logic [3:0] error_group
);

    logic        push;
    char_class_t push_data;
    logic        pop;
    char_class_t pop_data;
    logic        q_not_empty;
    logic        q_full;

    natv_front u_front (
        .addr_valid (addr_valid),
        .addr_stall (addr_stall),
        .addr_char  (addr_char),
        .is_last    (is_last),
        .queue_full (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    natv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    natv_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_data       (pop_data),
        .q_pop        (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .addr_kind    (addr_kind),
        .error_code   (error_code),
        .error_group  (error_group)
    );

endmodule

// File: verif/natv_verdict_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// natv_verdict_check: result predictor and comparator for the address validator
// Tracks every accepted character with its own dotted, hex, colon-pair and
// dash-pair group trackers. It predicts the verdict of each string and checks
// each result beat, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module natv_verdict_check
    import natv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       addr_valid,
    input  logic       addr_stall,
    input  logic [7:0] addr_char,
    input  logic       is_last,
    input  logic       result_valid,
    input  logic       result_stall,
    input  logic [2:0] addr_kind,
    input  logic [3:0] error_code,
    input  logic [3:0] error_group,
    output int         fail_count,
    output int         pending_results,
    output int         results_checked
);

    typedef enum logic [1:0] {SPLIT_DECIMAL, SPLIT_HEX, SPLIT_PAIR} split_mode_t;

    typedef struct packed {
        logic [3:0] splits;
        logic [2:0] run_len;
        logic [8:0] octet;
        logic       bad_char;
        logic       zero_first;
        logic [3:0] fault;
        logic [3:0] fault_grp;
    } group_track_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] code;
        logic [3:0] grp;
    } address_verdict_t;

    group_track_t     dot_trk;
    group_track_t     hex_trk;
    group_track_t     colon_trk;
    group_track_t     dash_trk;
    logic             had_dot;
    logic             had_colon;
    logic             had_dash;
    address_verdict_t expected_verdicts[$];
    address_verdict_t oldest;

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_hex_digit(logic [7:0] c);
        return is_digit(c) || (c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F);
    endfunction

    // 1-based group number, pinned at 15 once the split count reaches 14
    function automatic logic [3:0] ordinal(logic [3:0] splits);
        if (splits == SEPS_SAT || splits == SEPS_SAT - 4'd1)
            return SEPS_SAT;
        return splits + 4'd1;
    endfunction

    // latch the first fault of the group that just ended
    function automatic group_track_t seal(group_track_t t, split_mode_t m);
        logic [3:0] f;
        f = ERR_NONE;
        if (t.fault != ERR_NONE)
            return t;
        if (t.run_len == 3'd0)
            f = ERR_EMPTY;
        else if (m == SPLIT_DECIMAL)
        begin
            if (t.bad_char)
                f = ERR_NON_DIGIT;
            else if (t.run_len > 3'd1 && t.zero_first)
                f = ERR_LEAD_ZERO;
            else if (t.octet > OCTET_MAX)
                f = ERR_OVER_255;
        end
        else if (m == SPLIT_HEX)
        begin
            if (t.run_len > HEX_MAX_LEN)
                f = ERR_TOO_LONG;
            else if (t.bad_char)
                f = ERR_NON_HEX;
        end
        else
        begin
            if (t.run_len != PAIR_LEN)
                f = ERR_MAC_LEN;
            else if (t.bad_char)
                f = ERR_NON_HEX;
        end
        if (f != ERR_NONE)
        begin
            t.fault     = f;
            t.fault_grp = ordinal(t.splits);
        end
        return t;
    endfunction

    function automatic group_track_t absorb(group_track_t t, logic [7:0] c,
                                            logic [7:0] delim, split_mode_t m);
        int acc;
        if (c == delim)
        begin
            t = seal(t, m);
            if (t.splits != SEPS_SAT)
                t.splits = t.splits + 4'd1;
            t.run_len    = '0;
            t.octet      = '0;
            t.bad_char   = 1'b0;
            t.zero_first = 1'b0;
            return t;
        end
        if (t.run_len == 3'd0 && c == CH_ZERO)
            t.zero_first = 1'b1;
        if (t.run_len != LEN_SAT)
            t.run_len = t.run_len + 3'd1;
        if (m == SPLIT_DECIMAL)
        begin
            if (!is_digit(c))
                t.bad_char = 1'b1;
            else
            begin
                acc = int'(t.octet) * 10 + int'(c) - int'(CH_ZERO);
                t.octet = (acc > int'(VAL_SAT)) ? VAL_SAT : acc[8:0];
            end
        end
        else if (!is_hex_digit(c))
            t.bad_char = 1'b1;
        return t;
    endfunction

    function automatic group_track_t wrap_up(group_track_t t, split_mode_t m,
                                             logic [3:0] need);
        t = seal(t, m);
        if (t.fault == ERR_NONE && ordinal(t.splits) != need)
        begin
            t.fault     = ERR_GRP_COUNT;
            t.fault_grp = '0;
        end
        return t;
    endfunction

    function automatic address_verdict_t classify(group_track_t dot_t, group_track_t hex_t,
                                                  group_track_t colon_t, group_track_t dash_t,
                                                  logic saw_dot, logic saw_colon,
                                                  logic saw_dash);
        address_verdict_t v;
        group_track_t     chosen;
        logic [2:0]       good;
        logic             picked;
        v.kind = KIND_UNKNOWN;
        v.code = ERR_NONE;
        v.grp  = '0;
        picked = 1'b1;
        chosen = dot_t;
        good   = KIND_IPV4;
        if (saw_dot)
        begin
            chosen = dot_t;
            good   = KIND_IPV4;
        end
        else if (saw_colon)
        begin
            if (hex_t.fault == ERR_NONE)
            begin
                chosen = hex_t;
                good   = KIND_IPV6;
            end
            else
            begin
                // a dash anywhere switches the pair split over to dashes
                chosen = saw_dash ? dash_t : colon_t;
                good   = KIND_MAC;
            end
        end
        else if (saw_dash)
        begin
            chosen = dash_t;
            good   = KIND_MAC;
        end
        else
            picked = 1'b0;
        if (picked)
        begin
            if (chosen.fault == ERR_NONE)
                v.kind = good;
            else
            begin
                v.kind = KIND_INVALID;
                v.code = chosen.fault;
                v.grp  = chosen.fault_grp;
            end
        end
        return v;
    endfunction

    task automatic clear_trackers();
        dot_trk   = '0;
        hex_trk   = '0;
        colon_trk = '0;
        dash_trk  = '0;
        had_dot   = 1'b0;
        had_colon = 1'b0;
        had_dash  = 1'b0;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_trackers();
            expected_verdicts.delete();
            fail_count      = 0;
            results_checked = 0;
            pending_results = 0;
        end
        else
        begin
            if (addr_valid && !addr_stall)
            begin
                if (addr_char == CH_DOT)
                    had_dot = 1'b1;
                if (addr_char == CH_COLON)
                    had_colon = 1'b1;
                if (addr_char == CH_DASH)
                    had_dash = 1'b1;
                dot_trk   = absorb(dot_trk, addr_char, CH_DOT, SPLIT_DECIMAL);
                hex_trk   = absorb(hex_trk, addr_char, CH_COLON, SPLIT_HEX);
                colon_trk = absorb(colon_trk, addr_char, CH_COLON, SPLIT_PAIR);
                dash_trk  = absorb(dash_trk, addr_char, CH_DASH, SPLIT_PAIR);
                if (is_last)
                begin
                    expected_verdicts.push_back(classify(
                        wrap_up(dot_trk, SPLIT_DECIMAL, NEED_DOT),
                        wrap_up(hex_trk, SPLIT_HEX, NEED_HEX),
                        wrap_up(colon_trk, SPLIT_PAIR, NEED_PAIR),
                        wrap_up(dash_trk, SPLIT_PAIR, NEED_PAIR),
                        had_dot, had_colon, had_dash));
                    clear_trackers();
                end
            end
            if (result_valid && !result_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("result beat with no string outstanding: kind %0d code %0d group %0d",
                           addr_kind, error_code, error_group);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_verdicts.pop_front();
                    check_field("addr_kind", int'(oldest.kind), int'(addr_kind));
                    check_field("error_code", int'(oldest.code), int'(error_code));
                    check_field("error_group", int'(oldest.grp), int'(error_group));
                    results_checked++;
                end
            end
            pending_results = expected_verdicts.size();
        end
    end

endmodule

// File: verif/network_address_text_validator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// network_address_text_validator_tb: stimulus and verdict for the validator
// Feeds directed address strings, then random well-formed and broken IPv4,
// IPv6 and MAC strings plus noise, under three sender/receiver idle profiles.
// The verdict checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module network_address_text_validator_tb;
    import natv_pkg::*;

    localparam int SHAPE_DOTTED     = 0;
    localparam int SHAPE_HEX        = 1;
    localparam int SHAPE_COLON_PAIR = 2;
    localparam int SHAPE_DASH_PAIR  = 3;
    localparam int SHAPE_NOISE      = 4;

    localparam int FLAW_NONE   = 0;
    localparam int FLAW_EMPTY  = 1;
    localparam int FLAW_LENGTH = 2;
    localparam int FLAW_CHAR   = 3;
    localparam int FLAW_RANGE  = 4;
    localparam int FLAW_COUNT  = 5;
    localparam int FLAW_MIX    = 6;

    logic       clk;
    logic       rst_n;
    logic       addr_valid;
    logic       addr_stall;
    logic [7:0] addr_char;
    logic       is_last;
    logic       result_valid;
    logic       result_stall;
    logic [2:0] addr_kind;
    logic [3:0] error_code;
    logic [3:0] error_group;

    int fail_count;
    int pending_results;
    int results_checked;
    int send_idle_pct = 7;
    int recv_idle_pct = 70;
    int chars_sent    = 0;
    int strings_sent  = 0;

    logic [7:0] text_q[$];

    network_address_text_validator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .addr_valid   (addr_valid),
        .addr_stall   (addr_stall),
        .addr_char    (addr_char),
        .is_last      (is_last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .addr_kind    (addr_kind),
        .error_code   (error_code),
        .error_group  (error_group)
    );

    natv_verdict_check verdict_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .addr_valid      (addr_valid),
        .addr_stall      (addr_stall),
        .addr_char       (addr_char),
        .is_last         (is_last),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .addr_kind       (addr_kind),
        .error_code      (error_code),
        .error_group     (error_group),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver backpressure, one draw per cycle
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        #2ms;
        $error("timeout: stimulus or results stopped moving");
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [7:0] digit_char(int d);
        logic [7:0] b;
        b = d[7:0];
        return CH_ZERO + b;
    endfunction

    function automatic logic [7:0] pick_hex();
        int         r;
        logic [7:0] b;
        r = $urandom_range(21);
        b = r[7:0];
        if (r < 10)
            return CH_ZERO + b;
        if (r < 16)
            return CH_LO_A + b - 8'd10;
        return CH_UP_A + b - 8'd16;
    endfunction

    function automatic logic [7:0] pick_junk();
        logic [7:0] b;
        case ($urandom_range(4))
            0: b = 8'h00;
            1: b = 8'($urandom_range(128, 255));
            2: b = CH_LO_F + 8'd1 + 8'($urandom_range(19));
            3: b = CH_LO_A + 8'($urandom_range(5));
            default: b = 8'($urandom_range(255));
        endcase
        return b;
    endfunction

    function automatic logic [7:0] pick_separator();
        case ($urandom_range(2))
            0: return CH_DOT;
            1: return CH_COLON;
            default: return CH_DASH;
        endcase
    endfunction

    // hold the beat until the block takes it
    task automatic send_char(input logic [7:0] c, input logic final_char);
        while ($urandom_range(99) < send_idle_pct)
        begin
            addr_valid <= 1'b0;
            @(posedge clk);
        end
        addr_valid <= 1'b1;
        addr_char  <= c;
        is_last    <= final_char;
        @(posedge clk);
        while (addr_stall)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_queue();
        int n;
        n = text_q.size();
        for (int k = 0; k < n; k++)
            send_char(text_q[k], k == n - 1);
        text_q.delete();
        strings_sent++;
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++)
            text_q.push_back(s[k]);
    endtask

    task automatic send_text(input string s);
        add_text(s);
        send_queue();
    endtask

    task automatic push_decimal(input int v);
        if (v >= 100)
            text_q.push_back(digit_char(v / 100));
        if (v >= 10)
            text_q.push_back(digit_char((v / 10) % 10));
        text_q.push_back(digit_char(v % 10));
    endtask

    task automatic emit_group(input int shape, input int flaw);
        int n;
        int v;
        int spot;
        if (shape == SHAPE_DOTTED)
        begin
            v = (flaw == FLAW_RANGE) ? $urandom_range(256, 999) : $urandom_range(255);
            if (flaw == FLAW_LENGTH)
                text_q.push_back(CH_ZERO);
            push_decimal(v);
            if (flaw == FLAW_CHAR)
                text_q.push_back(pick_junk());
        end
        else
        begin
            if (shape == SHAPE_HEX)
                n = (flaw == FLAW_LENGTH) ? $urandom_range(5, 7) : $urandom_range(1, 4);
            else if (flaw == FLAW_LENGTH)
                n = $urandom_range(1) ? 1 : 3;
            else
                n = 2;
            spot = (flaw == FLAW_CHAR || flaw == FLAW_RANGE) ? $urandom_range(n - 1) : -1;
            for (int k = 0; k < n; k++)
                text_q.push_back((k == spot) ? pick_junk() : pick_hex());
        end
    endtask

    // one random string: mostly well-formed groups, some with a single flaw
    task automatic build_address();
        int         roll;
        int         shape;
        int         flaw;
        int         groups;
        int         flaw_at;
        logic [7:0] sep;
        roll = $urandom_range(99);
        if (roll < 30)
            shape = SHAPE_DOTTED;
        else if (roll < 55)
            shape = SHAPE_HEX;
        else if (roll < 70)
            shape = SHAPE_COLON_PAIR;
        else if (roll < 88)
            shape = SHAPE_DASH_PAIR;
        else
            shape = SHAPE_NOISE;

        if (shape == SHAPE_NOISE)
        begin
            repeat ($urandom_range(1, 10))
            begin
                case ($urandom_range(3))
                    0: text_q.push_back(8'($urandom_range(255)));
                    1: text_q.push_back(pick_separator());
                    2: text_q.push_back(pick_hex());
                    default: text_q.push_back(pick_junk());
                endcase
            end
            return;
        end

        case (shape)
            SHAPE_DOTTED:
            begin
                groups = int'(NEED_DOT);
                sep    = CH_DOT;
            end
            SHAPE_HEX:
            begin
                groups = int'(NEED_HEX);
                sep    = CH_COLON;
            end
            SHAPE_COLON_PAIR:
            begin
                groups = int'(NEED_PAIR);
                sep    = CH_COLON;
            end
            default:
            begin
                groups = int'(NEED_PAIR);
                sep    = CH_DASH;
            end
        endcase

        flaw = ($urandom_range(99) < 35) ? $urandom_range(FLAW_EMPTY, FLAW_MIX) : FLAW_NONE;
        if (flaw == FLAW_COUNT)
        begin
            // sometimes run to 14 to 18 groups, around where the group number saturates at 15
            if ($urandom_range(3) == 0)
                groups = $urandom_range(14, 18);
            else
                groups = groups + ($urandom_range(1) ? 1 : -1);
        end
        flaw_at = $urandom_range(groups - 1);

        for (int g = 0; g < groups; g++)
        begin
            if (g > 0)
                text_q.push_back((flaw == FLAW_MIX && g == flaw_at) ? pick_separator() : sep);
            if (!(flaw == FLAW_EMPTY && g == flaw_at))
                emit_group(shape, (g == flaw_at) ? flaw : FLAW_NONE);
        end
        // a lone empty group leaves nothing to send
        if (text_q.size() == 0)
            text_q.push_back(sep);
    endtask

    task automatic run_directed();
        send_text("255.0.10.199");
        send_text("0.0.0.0");
        send_text("1.2.3");
        send_text("01.2.3.4");
        send_text("256.1.1.1");
        send_text("1..2.3");
        send_text("1.2.3.4.");
        send_text("1.a.3.4");
        send_text("1.2:3.4");
        send_text("fe80:0:0:0:0:0:0:1");
        send_text("12345:1:2:3:4:5:6:7");
        send_text("1:2:3:4:5:6:7:g");
        send_text("AA:bb:CC:dd:EE:ff");
        send_text("00-1A-2b-3C-4d-5E");
        send_text("0a:1b-2c:3d");
        send_text("1-2-3");
        send_text(":");
        send_text("hello");
        // odd bytes: NUL, top-bit characters
        text_q.push_back(8'h00);
        send_queue();
        add_text("1.2.");
        text_q.push_back(8'hC1);
        add_text(".4");
        send_queue();
        text_q.push_back(8'hFF);
        text_q.push_back(8'h80);
        send_queue();
        // group numbers past 15 saturate
        for (int k = 0; k < 16; k++)
            add_text("aa:");
        send_text("a");
        for (int k = 0; k < 16; k++)
            add_text("1.");
        send_text("256");
        for (int k = 0; k < 17; k++)
            add_text("1.");
        send_text("1");
    endtask

    initial
    begin
        int phase_chars;
        int phase_strings;
        rst_n      = 1'b0;
        addr_valid = 1'b0;
        addr_char  = '0;
        is_last    = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 7;
                    recv_idle_pct = 70;
                end
                1:
                begin
                    send_idle_pct = 70;
                    recv_idle_pct = 7;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (p == 0)
                run_directed();
            phase_chars   = chars_sent;
            phase_strings = strings_sent;
            while (chars_sent - phase_chars < 110 || strings_sent - phase_strings < 5)
            begin
                build_address();
                send_queue();
            end
        end
        addr_valid <= 1'b0;
        @(posedge clk);

        // drain: wait for every outstanding result, plus margin
        while (pending_results != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d address strings (%0d characters) under three idle profiles",
                 strings_sent, chars_sent);
        $display("%0d result beats matched against predictions, %0d mismatches",
                 results_checked, fail_count);
        if (fail_count == 0 && pending_results == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/natv_pkg.sv
hw/rtl/natv_front.sv
hw/rtl/natv_queue.sv
hw/rtl/natv_checker.sv
hw/rtl/natv_back.sv
hw/rtl/network_address_text_validator.sv
verif/natv_verdict_check.sv
verif/network_address_text_validator_tb.sv
